FILE: hdl/assert_macros.svh
// Assertion macros shared by the layer normalization RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset
`define LN_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("same-cycle implication failed");
// Next-cycle implication, disabled during reset
`define LN_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("next-cycle implication failed");
`endif

FILE: hdl/lnorm_pkg.sv
// Types, widths and register codes of the layer normalization block.
// Depends on nothing; imported by every other file but assert_macros.svh.
`default_nettype none
package lnorm_pkg;
	localparam int MAX_LENGTH = 4096;
	localparam int DATA_BITS  = 16;
	localparam int IDX_W      = $clog2(MAX_LENGTH);
	localparam int CNT_W      = IDX_W + 1;
	localparam int SUM_W      = DATA_BITS + CNT_W;
	localparam int SQ_W       = 2 * DATA_BITS + IDX_W;
	localparam int MEAN_W     = DATA_BITS + 8;
	localparam int INV_W      = 32;
	localparam int DVD_W      = SQ_W + 16;
	localparam int DSR_W      = SQ_W + 1;
	localparam int CNTR_W     = $clog2(DVD_W + 1);
	localparam int ROOT_W     = 50;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam int LEN_W = 13;
	localparam int EPS_W = 16;
	localparam int PADDR_W = 3;
	localparam logic [PADDR_W-1:0] ADDR_LENGTH  = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_EPSILON = 3'd4;
	localparam logic [LEN_W-1:0] LENGTH_RESET  = 13'd2560;
	localparam logic [EPS_W-1:0] EPSILON_RESET = 16'd1;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'b01,
		CMD_DRAIN = 2'b10
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                    kind;
		logic                         fin;
		logic [IDX_W-1:0]             idx;
		logic signed [DATA_BITS-1:0]  sample;
		logic signed [DATA_BITS-1:0]  scale;
		logic signed [DATA_BITS-1:0]  offset;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quotient;
		logic [DSR_W-1:0] remainder;
	} div_rsp_t;
endpackage
`default_nettype wire

FILE: hdl/lnorm_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on lnorm_pkg.
`default_nettype none
interface lnorm_in_if;
	import lnorm_pkg::*;
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic signed [DATA_BITS-1:0] sample_value;
	logic signed [DATA_BITS-1:0] scale_value;
	logic signed [DATA_BITS-1:0] offset_value;
	modport source (output valid, opcode, sample_value, scale_value, offset_value,
		input ready);
	modport sink (input valid, opcode, sample_value, scale_value, offset_value,
		output ready);
endinterface

interface lnorm_out_if;
	import lnorm_pkg::*;
	logic                        valid;
	logic                        ready;
	logic signed [DATA_BITS-1:0] normalized_value;
	logic [IDX_W-1:0]            element_index;
	logic                        last_flag;
	modport source (output valid, normalized_value, element_index, last_flag,
		input ready);
	modport sink (input valid, normalized_value, element_index, last_flag,
		output ready);
endinterface
`default_nettype wire

FILE: hdl/layer_normalization.sv
// Layer normalization over vectors of signed Q8.8 elements. Load items
// (opcode 0) store an element with its scale and offset; the load that
// completes the configured length starts a finish sequence of up to three
// 60-step divisions and a 25-step square root, during which queued items
// wait. Drain items (opcode 1) then return one result each at one item per
// cycle unless the output stalls, through a four-stage pipeline; items
// outside their phase give no result. A four-entry command queue parts intake
// from the datapath. Registers: vector_length at 0x0, epsilon_q at 0x4.
// Depends on lnorm_pkg, lnorm_if, lnorm_front, lnorm_fifo, lnorm_back.
`default_nettype none
module layer_normalization (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [lnorm_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	lnorm_in_if.sink                       in_ch,
	lnorm_out_if.source                    out_ch
);
	import lnorm_pkg::*;

	logic [LEN_W-1:0] length_q;
	logic [EPS_W-1:0] epsilon_q;
	logic [CNT_W-1:0] len_eff;
	logic             wr;
	logic             push;
	logic             pop;
	cmd_t             push_cmd;
	cmd_t             head;
	fifo_stat_t       fifo_stat;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q  <= LENGTH_RESET;
			epsilon_q <= EPSILON_RESET;
		end else if (wr) begin
			unique case (paddr)
				ADDR_LENGTH:  length_q  <= pwdata[LEN_W-1:0];
				ADDR_EPSILON: epsilon_q <= pwdata[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (paddr)
			ADDR_LENGTH:  prdata = 32'(length_q);
			ADDR_EPSILON: prdata = 32'(epsilon_q);
			default:      prdata = '0;
		endcase
	end

	// Clamp length into one to the store depth
	always_comb begin
		if (length_q == '0) begin
			len_eff = CNT_W'(1);
		end else if (CNT_W'(length_q) > CNT_W'(MAX_LENGTH)) begin
			len_eff = CNT_W'(MAX_LENGTH);
		end else begin
			len_eff = CNT_W'(length_q);
		end
	end

	lnorm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.len_eff   (len_eff),
		.fifo_stat (fifo_stat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	lnorm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (fifo_stat)
	);

	lnorm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.fifo_stat (fifo_stat),
		.pop       (pop),
		.epsilon_q (epsilon_q),
		.out_ch    (out_ch)
	);
endmodule
`default_nettype wire

FILE: hdl/lnorm_fifo.sv
// Short command queue between the front and the back.
// Depends on lnorm_pkg and assert_macros.svh.
`default_nettype none
module lnorm_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire lnorm_pkg::cmd_t push_cmd,
	input  wire logic            pop,
	output lnorm_pkg::cmd_t      head,
	output lnorm_pkg::fifo_stat_t stat
);
	import lnorm_pkg::*;
	`include "assert_macros.svh"

	cmd_t               slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   cnt_q;

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

	assign head = slot_q[rd_q];
	assign stat = '{full: (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH)), empty: (cnt_q == '0)};

	`LN_ASSERT_IMPL(a_no_overflow, clk, arst_n, push, !stat.full)
	`LN_ASSERT_IMPL(a_no_underflow, clk, arst_n, pop, !stat.empty)
endmodule
`default_nettype wire

FILE: hdl/lnorm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lnorm_pkg and assert_macros.svh.
`default_nettype none
module lnorm_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lnorm_pkg::div_req_t req,
	output lnorm_pkg::div_rsp_t    rsp
);
	import lnorm_pkg::*;
	`include "assert_macros.svh"

	logic [DVD_W-1:0]  quo_q;
	logic [DSR_W-1:0]  rem_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [CNTR_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DSR_W:0]    rem_sh;
	logic [DSR_W:0]    rem_sub;
	logic              take;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		rem_sh  = {rem_q, quo_q[DVD_W-1]};
		rem_sub = rem_sh - {1'b0, dsr_q};
		take    = (rem_sh >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], take};
			rem_q <= take ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
		end
	end

	// Count the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTR_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTR_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp = '{busy: busy_q, done: done_q, quotient: quo_q, remainder: rem_q};

	`LN_ASSERT_IMPL(a_start_idle, clk, arst_n, req.start, !busy_q)
endmodule
`default_nettype wire

FILE: hdl/lnorm_front.sv
// Front end: accepts items, tracks load/drain phase, queues commands.
// Depends on lnorm_pkg and lnorm_if.
`default_nettype none
module lnorm_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	lnorm_in_if.sink                   in_ch,
	input  wire logic [lnorm_pkg::CNT_W-1:0] len_eff,
	input  wire lnorm_pkg::fifo_stat_t fifo_stat,
	output logic                       push,
	output lnorm_pkg::cmd_t            push_cmd
);
	import lnorm_pkg::*;

	logic             draining_q;
	logic [CNT_W-1:0] count_q;
	logic             accept;
	logic             use_it;
	logic             at_end;
	logic [CNT_W-1:0] count_nx;

	assign in_ch.ready = !fifo_stat.full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign count_nx    = count_q + 1'b1;
	assign at_end      = (count_nx >= len_eff);
	// Loads count only while loading, drains only while draining
	assign use_it      = (in_ch.opcode == OP_DRAIN) ? draining_q : !draining_q;
	assign push        = accept && use_it;

	always_comb begin
		push_cmd.kind   = (in_ch.opcode == OP_DRAIN) ? CMD_DRAIN : CMD_LOAD;
		push_cmd.fin    = at_end;
		push_cmd.idx    = count_q[IDX_W-1:0];
		push_cmd.sample = in_ch.sample_value;
		push_cmd.scale  = in_ch.scale_value;
		push_cmd.offset = in_ch.offset_value;
	end

	// Advance the element count, flip phase at the end of a vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			count_q    <= '0;
		end else if (push) begin
			if (at_end) begin
				count_q    <= '0;
				draining_q <= !draining_q;
			end else begin
				count_q <= count_nx;
			end
		end
	end
endmodule
`default_nettype wire

FILE: hdl/lnorm_back.sv
// Back end: element store, statistics, finish sequencer, drain datapath.
// Depends on lnorm_pkg, lnorm_if, lnorm_div and assert_macros.svh.
`default_nettype none
module lnorm_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lnorm_pkg::cmd_t       head,
	input  wire lnorm_pkg::fifo_stat_t fifo_stat,
	output logic                       pop,
	input  wire logic [lnorm_pkg::EPS_W-1:0] epsilon_q,
	lnorm_out_if.source                out_ch
);
	import lnorm_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [6:0] {
		F_IDLE = 7'b0000001,
		F_MEAN = 7'b0000010,
		F_SQ   = 7'b0000100,
		F_MSQ  = 7'b0001000,
		F_VAR  = 7'b0010000,
		F_INV  = 7'b0100000,
		F_SQRT = 7'b1000000
	} fin_state_t;

	typedef struct packed {
		logic signed [DATA_BITS-1:0] sample;
		logic signed [DATA_BITS-1:0] scale;
		logic signed [DATA_BITS-1:0] offset;
	} elem_t;

	elem_t mem [MAX_LENGTH];

	fin_state_t               state_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]          sq_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     neg_q;
	logic signed [MEAN_W-1:0] mean_q;
	logic [INV_W-1:0]         inv_q;
	logic [DVD_W-1:0]         qsq_q;
	logic [2*MEAN_W-1:0]      msq_q;
	logic [ROOT_W-1:0]        sqv_q;
	logic [ROOT_W-1:0]        root_q;
	logic [ROOT_W-1:0]        bit_q;
	logic                     div_start_q;
	logic [DVD_W-1:0]         div_dvd_q;
	logic [DSR_W-1:0]         div_dsr_q;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;

	logic                     en;
	logic                     load_pop;
	logic                     drain_pop;
	logic signed [SUM_W-1:0]  sum_nx;
	logic signed [2*DATA_BITS-1:0] sqr;
	logic [SQ_W-1:0]          sq_nx;
	logic [SUM_W-1:0]         sum_abs;
	logic [MEAN_W-1:0]        quo_mean;
	logic [MEAN_W-1:0]        mean_abs;
	logic signed [DVD_W:0]    var32;
	logic [SQ_W-1:0]          var16;
	logic [DSR_W-1:0]         dev;
	logic [ROOT_W-1:0]        try_w;
	logic                     fit;
	logic [ROOT_W-1:0]        root_nx;

	// Drain pipeline registers
	logic                        s1_v, s2_v, s3_v, out_v_q;
	elem_t                       rd_s1;
	logic [IDX_W-1:0]            idx_s1, idx_s2, idx_s3;
	logic                        last_s1, last_s2, last_s3;
	logic signed [57:0]          p_s2;
	logic signed [DATA_BITS-1:0] scale_s2;
	logic signed [DATA_BITS-1:0] off_s2, off_s3;
	logic signed [57:0]          t_s3;
	logic signed [DATA_BITS-1:0] y_q;
	logic [IDX_W-1:0]            idx_q;
	logic                        last_q;

	logic signed [MEAN_W:0]      diff;
	logic signed [57:0]          p_nx;
	logic signed [41:0]          q_w;
	logic signed [57:0]          t_nx;
	logic signed [57:0]          t_rnd;
	logic signed [42:0]          y_w;

	assign div_req = '{start: div_start_q, dividend: div_dvd_q, divisor: div_dsr_q};

	lnorm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Global advance of the drain pipeline
	assign en = !out_v_q || out_ch.ready;

	// Take a command: loads while idle, the finishing load only once
	// stage one is clear, drains only when the pipeline moves
	always_comb begin
		load_pop  = 1'b0;
		drain_pop = 1'b0;
		if (!fifo_stat.empty && state_q == F_IDLE) begin
			if (head.kind == CMD_LOAD) begin
				load_pop = !head.fin || !s1_v;
			end else begin
				drain_pop = en;
			end
		end
	end
	assign pop = load_pop || drain_pop;

	// Running sums including the current load
	always_comb begin
		sum_nx  = sum_q + SUM_W'(head.sample);
		sqr     = head.sample * head.sample;
		sq_nx   = sq_q + SQ_W'(unsigned'(sqr));
		sum_abs = sum_nx[SUM_W-1] ? SUM_W'(-sum_nx) : SUM_W'(sum_nx);
	end

	// Mean rounds toward minus infinity
	always_comb begin
		quo_mean = div_rsp.quotient[MEAN_W-1:0];
		if (neg_q) begin
			quo_mean = -(quo_mean + MEAN_W'(div_rsp.remainder != '0));
		end
	end

	// Magnitude of the mean; the most negative mean squares to 2^46
	assign mean_abs = mean_q[MEAN_W-1] ? MEAN_W'(-mean_q) : MEAN_W'(mean_q);

	// Variance, clamped at zero, plus epsilon
	always_comb begin
		var32 = $signed({1'b0, qsq_q}) - $signed((DVD_W+1)'(msq_q));
		var16 = var32[DVD_W] ? '0 : var32[SQ_W+15:16];
		dev   = DSR_W'(var16) + DSR_W'(epsilon_q);
	end

	// One bit of the integer square root
	always_comb begin
		try_w   = root_q + bit_q;
		fit     = (sqv_q >= try_w);
		root_nx = fit ? ((root_q >> 1) + bit_q) : (root_q >> 1);
	end

	// Store loaded elements, read for drains
	always_ff @(posedge clk) begin
		if (load_pop) begin
			mem[head.idx] <= '{sample: head.sample, scale: head.scale,
				offset: head.offset};
		end
		if (drain_pop) begin
			rd_s1 <= mem[head.idx];
		end
	end

	// Finish sequencer: mean, variance, inverse deviation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			sum_q       <= '0;
			sq_q        <= '0;
			cnt_q       <= '0;
			mean_q      <= '0;
			inv_q       <= '0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (load_pop) begin
						sum_q <= sum_nx;
						sq_q  <= sq_nx;
						cnt_q <= cnt_q + 1'b1;
						if (head.fin) begin
							state_q     <= F_MEAN;
							div_start_q <= 1'b1;
						end
					end
				end
				F_MEAN: begin
					if (div_rsp.done) begin
						mean_q      <= quo_mean;
						state_q     <= F_SQ;
						div_start_q <= 1'b1;
					end
				end
				F_SQ: begin
					if (div_rsp.done) begin
						sum_q   <= '0;
						sq_q    <= '0;
						cnt_q   <= '0;
						state_q <= F_MSQ;
					end
				end
				F_MSQ: begin
					state_q <= F_VAR;
				end
				F_VAR: begin
					if (dev == '0) begin
						inv_q   <= '1;
						state_q <= F_IDLE;
					end else begin
						div_start_q <= 1'b1;
						state_q     <= F_INV;
					end
				end
				F_INV: begin
					if (div_rsp.done) begin
						state_q <= F_SQRT;
					end
				end
				F_SQRT: begin
					if (bit_q[0]) begin
						inv_q   <= root_nx[INV_W-1:0];
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Sequencer payload: divider operands and root iteration
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && load_pop && head.fin) begin
			neg_q     <= sum_nx[SUM_W-1];
			div_dvd_q <= DVD_W'({sum_abs, 8'h00});
			div_dsr_q <= DSR_W'(cnt_q + 1'b1);
		end
		if (state_q == F_MEAN && div_rsp.done) begin
			div_dvd_q <= {sq_q, 16'h0000};
		end
		if (state_q == F_SQ && div_rsp.done) begin
			qsq_q <= div_rsp.quotient;
		end
		if (state_q == F_MSQ) begin
			msq_q <= mean_abs * mean_abs;
		end
		if (state_q == F_VAR) begin
			div_dvd_q <= DVD_W'(1) << 48;
			div_dsr_q <= dev;
		end
		if (state_q == F_INV && div_rsp.done) begin
			sqv_q  <= div_rsp.quotient[ROOT_W-1:0];
			root_q <= '0;
			bit_q  <= ROOT_W'(1) << 48;
		end
		if (state_q == F_SQRT) begin
			if (fit) sqv_q <= sqv_q - try_w;
			root_q <= root_nx;
			bit_q  <= bit_q >> 2;
		end
	end

	// Drain arithmetic: center, scale by inverse deviation, weight, round
	always_comb begin
		diff  = $signed({rd_s1.sample[DATA_BITS-1], rd_s1.sample, 8'h00}) -
			$signed({mean_q[MEAN_W-1], mean_q});
		p_nx  = diff * $signed({1'b0, inv_q});
		q_w   = p_s2[57:16];
		t_nx  = q_w * scale_s2;
		t_rnd = t_s3 + 58'sd32768;
		y_w   = $signed({t_rnd[57], t_rnd[57:16]}) + 43'(off_s3);
	end

	// Advance pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v    <= 1'b0;
			s2_v    <= 1'b0;
			s3_v    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			s1_v    <= drain_pop;
			s2_v    <= s1_v;
			s3_v    <= s2_v;
			out_v_q <= s3_v;
		end
	end

	// Advance pipeline payload, saturate into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1   <= head.idx;
			last_s1  <= head.fin;
			p_s2     <= p_nx;
			scale_s2 <= rd_s1.scale;
			off_s2   <= rd_s1.offset;
			idx_s2   <= idx_s1;
			last_s2  <= last_s1;
			t_s3     <= t_nx;
			off_s3   <= off_s2;
			idx_s3   <= idx_s2;
			last_s3  <= last_s2;
			idx_q    <= idx_s3;
			last_q   <= last_s3;
			if (y_w > 43'sd32767) begin
				y_q <= 16'sh7fff;
			end else if (y_w < -43'sd32768) begin
				y_q <= 16'sh8000;
			end else begin
				y_q <= y_w[DATA_BITS-1:0];
			end
		end
	end

	assign out_ch.valid            = out_v_q;
	assign out_ch.normalized_value = y_q;
	assign out_ch.element_index    = idx_q;
	assign out_ch.last_flag        = last_q;

	`LN_ASSERT_IMPL(a_finish_clear, clk, arst_n, state_q != F_IDLE, !s1_v)
	`LN_ASSERT_NEXT(a_drain_reads, clk, arst_n, drain_pop && en, s1_v)
endmodule
`default_nettype wire
